// ===== rtl/three_probe_bloom_filter_defines.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef THREE_PROBE_BLOOM_FILTER_DEFINES_SVH
`define THREE_PROBE_BLOOM_FILTER_DEFINES_SVH

// Same-cycle implication.
`define TPBF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication: the consequent is checked later than the antecedent.
`define TPBF_ASSERT_AFTER3(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpbf_pkg.sv =====
package tpbf_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int PROBES      = 3;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;
    localparam int RESULT_W    = 97;

    localparam logic [1:0] PROBE_MID  = 2'd1;
    localparam logic [1:0] PROBE_LAST = 2'd2;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // first member lands in the highest bits
    typedef struct packed {
        logic [COUNT_W-1:0] queries_hit;
        logic [COUNT_W-1:0] queries_missed;
        logic [COUNT_W-1:0] adds_seen;
        logic               present;
    } t_result;

endpackage

// ===== rtl/tpbf_result_fifo.sv =====
module tpbf_result_fifo
    import tpbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data,
    output logic [1:0] o_count
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/three_probe_bloom_filter.sv =====
// Channel  Dir  tuser        tdata
// s_axis   in   action       probe_word_0, probe_word_1, probe_word_2
// m_axis   out  -            present, adds_seen, queries_missed, queries_hit
//
// The three probes go through one read and one write port of the byte store, one
// read-modify-write per cycle; a new transaction waits until all three reads are issued.
// Result goes to a 2-entry output queue when the last probe returns; the queue absorbs
// stalls, and s_axis_tready drops while queue plus in-flight item is 2 and none pops.
// After reset the store is swept to zero, one byte per cycle, all 2^(FILTER_ADDR_BITS-3)
// bytes, with s_axis_tready low.
`include "three_probe_bloom_filter_defines.svh"

module three_probe_bloom_filter
    import tpbf_pkg::*;
#(
    parameter int FILTER_ADDR_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // probe_word_0, probe_word_1, probe_word_2
    input  logic                   s_axis_tuser,  // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // present, adds_seen, queries_missed,
                                                  // queries_hit, zero pad
);

    localparam int BYTE_AW = FILTER_ADDR_BITS - 3;
    localparam int DEPTH   = 1 << BYTE_AW;

    typedef enum logic {ST_CLEAR, ST_RUN} t_state;

    logic [7:0]                  r_mem [DEPTH];
    t_state                      r_state;
    logic [BYTE_AW-1:0]          r_clr_addr;

    logic [FILTER_ADDR_BITS-1:0] r_pos1;
    logic [FILTER_ADDR_BITS-1:0] r_pos2;
    logic                        r_action;
    logic                        r_busy;
    logic [1:0]                  r_idx;
    logic                        r_inflight;

    logic [7:0]                  r_rd_data;
    logic                        r_rd_vld;
    logic [BYTE_AW-1:0]          r_rd_addr;
    logic [2:0]                  r_rd_bit;
    logic                        r_rd_first;
    logic                        r_rd_last;
    logic                        r_all;

    logic                        r_wr_vld;
    logic [BYTE_AW-1:0]          r_wr_addr;
    logic [7:0]                  r_wr_data;

    logic [COUNT_W-1:0]          r_adds;
    logic [COUNT_W-1:0]          r_miss;
    logic [COUNT_W-1:0]          r_hit;
    logic [COUNT_W-1:0]          n_adds;
    logic [COUNT_W-1:0]          n_miss;
    logic [COUNT_W-1:0]          n_hit;

    logic                        accept;
    logic                        rd_en;
    logic [FILTER_ADDR_BITS-1:0] rd_pos;
    logic [7:0]                  cur_byte;
    logic [7:0]                  bit_mask;
    logic                        bit_set;
    logic                        all_now;
    logic                        land;
    logic                        is_add;
    logic                        wr_en;
    logic [BYTE_AW-1:0]          wr_addr;
    logic [7:0]                  wr_data;
    logic                        pop;
    logic [2:0]                  occupancy;
    logic [1:0]                  fifo_count;
    t_result                     res;
    t_result                     fifo_out;

    // ---------------- input side ----------------
    assign pop       = m_axis_tvalid && m_axis_tready;
    assign occupancy = {1'b0, fifo_count} + {2'b00, r_inflight};
    assign s_axis_tready = (r_state == ST_RUN) && !r_busy &&
                           ((occupancy < 3'd2) || ((occupancy == 3'd2) && pop));
    assign accept = s_axis_tvalid && s_axis_tready;

    // probe 0 is read straight from the bus in the accept cycle
    assign rd_en = accept || r_busy;
    always_comb begin
        if (accept) begin
            rd_pos = s_axis_tdata[FILTER_ADDR_BITS-1:0];
        end else if (r_idx == PROBE_MID) begin
            rd_pos = r_pos1;
        end else begin
            rd_pos = r_pos2;
        end
    end

    // ---------------- read-modify-write ----------------
    // a write lands at the same edge that the next read samples the store: forward it
    assign cur_byte = (r_wr_vld && (r_wr_addr == r_rd_addr)) ? r_wr_data : r_rd_data;
    assign bit_mask = 8'b0000_0001 << r_rd_bit;
    assign bit_set  = |(cur_byte & bit_mask);
    assign all_now  = (r_rd_first || r_all) && bit_set;
    assign land     = r_rd_vld && r_rd_last;
    assign is_add   = (r_action == ACT_ADD);

    assign wr_en   = (r_state == ST_CLEAR) || (r_rd_vld && is_add);
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_rd_addr;
    assign wr_data = (r_state == ST_CLEAR) ? 8'h00 : (cur_byte | bit_mask);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_pos[FILTER_ADDR_BITS-1:3]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // ---------------- counters ----------------
    assign n_adds = r_adds + COUNT_W'(is_add);
    assign n_hit  = r_hit  + COUNT_W'(!is_add && all_now);
    assign n_miss = r_miss + COUNT_W'(!is_add && !all_now);

    always_comb begin
        res.present        = !is_add && all_now;
        res.adds_seen      = n_adds;
        res.queries_missed = n_miss;
        res.queries_hit    = n_hit;
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_busy     <= 1'b0;
            r_idx      <= 2'd0;
            r_inflight <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_wr_vld   <= 1'b0;
            r_adds     <= '0;
            r_miss     <= '0;
            r_hit      <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BYTE_AW'(1);
                    if (&r_clr_addr) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: r_state <= ST_CLEAR;
            endcase

            if (accept) begin
                r_busy <= 1'b1;
                r_idx  <= PROBE_MID;
            end else if (r_busy) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == PROBE_LAST) begin
                    r_busy <= 1'b0;
                end
            end

            if (accept) begin
                r_inflight <= 1'b1;
            end else if (land) begin
                r_inflight <= 1'b0;
            end

            r_rd_vld <= rd_en;
            r_wr_vld <= wr_en;

            if (land) begin
                r_adds <= n_adds;
                r_miss <= n_miss;
                r_hit  <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= s_axis_tuser;
            r_pos1   <= s_axis_tdata[WORD_W +: FILTER_ADDR_BITS];
            r_pos2   <= s_axis_tdata[2*WORD_W +: FILTER_ADDR_BITS];
        end
        if (rd_en) begin
            r_rd_addr  <= rd_pos[FILTER_ADDR_BITS-1:3];
            r_rd_bit   <= rd_pos[2:0];
            r_rd_first <= accept;
            r_rd_last  <= !accept && (r_idx == PROBE_LAST);
        end
        if (r_rd_vld) begin
            r_all <= all_now;
        end
        r_wr_addr <= wr_addr;
        r_wr_data <= wr_data;
    end

    // ---------------- output side ----------------
    tpbf_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (land),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, fifo_out};

    // ---------------- assertions ----------------
    `TPBF_ASSERT_IMPL(a_no_accept_in_clear, r_state == ST_CLEAR, !s_axis_tready, "accept in clear")
    `TPBF_ASSERT_AFTER3(a_result_lands, accept, r_rd_vld && r_rd_last, "result did not land")
    `TPBF_ASSERT_IMPL(a_no_fifo_overflow, land, (fifo_count != 2'd2) || pop, "queue overflow")
    `TPBF_ASSERT_IMPL(a_busy_in_flight, r_busy, r_inflight, "probes issued with no transaction")

endmodule

// ===== test/three_probe_bloom_filter_tb.sv =====
`timescale 1ns / 100ps

module three_probe_bloom_filter_tb
    import tpbf_pkg::*;
();

    localparam int FILTER_ADDR_BITS = 20;
    localparam logic [WORD_W-1:0] POS_MASK = WORD_W'((64'd1 << FILTER_ADDR_BITS) - 1);
    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_MAX = 256;

    typedef logic [PROBES-1:0][WORD_W-1:0] t_probes;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // probe_word_0, probe_word_1, probe_word_2
    logic                   s_axis_tuser;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // present, adds_seen, queries_missed,
                                            // queries_hit, zero pad

    three_probe_bloom_filter #(
        .FILTER_ADDR_BITS(FILTER_ADDR_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Tracks the bit store and counters, queues the result each item should produce.
    class bloom_scoreboard;
        bit                 filter_map[];
        logic [COUNT_W-1:0] add_count;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] hit_count;
        t_result            pending_results[$];
        int                 mismatches;
        int                 results_checked;

        function new();
            filter_map = new[1 << FILTER_ADDR_BITS];
            add_count = '0;
            miss_count = '0;
            hit_count = '0;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void note_item(logic action, t_probes probes);
            t_result expected;
            bit      all_set;
            all_set = 1'b1;
            expected.present = 1'b0;
            if (action == ACT_ADD) begin
                add_count++;
                for (int i = 0; i < PROBES; i++)
                    filter_map[probes[i][FILTER_ADDR_BITS-1:0]] = 1'b1;
            end else begin
                // stops at the first clear bit
                for (int i = 0; i < PROBES && all_set; i++)
                    if (!filter_map[probes[i][FILTER_ADDR_BITS-1:0]])
                        all_set = 1'b0;
                if (all_set) begin
                    hit_count++;
                    expected.present = 1'b1;
                end else begin
                    miss_count++;
                end
            end
            expected.adds_seen = add_count;
            expected.queries_missed = miss_count;
            expected.queries_hit = hit_count;
            pending_results.push_back(expected);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_result got;
            t_result want;
            got = t_result'(tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction on m_axis, expected none, actual %h",
                         $time, tdata);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.present !== want.present) begin
                $display("%0t: present expected %0b actual %0b",
                         $time, want.present, got.present);
                mismatches++;
            end
            if (got.adds_seen !== want.adds_seen) begin
                $display("%0t: adds_seen expected %0d actual %0d",
                         $time, want.adds_seen, got.adds_seen);
                mismatches++;
            end
            if (got.queries_missed !== want.queries_missed) begin
                $display("%0t: queries_missed expected %0d actual %0d",
                         $time, want.queries_missed, got.queries_missed);
                mismatches++;
            end
            if (got.queries_hit !== want.queries_hit) begin
                $display("%0t: queries_hit expected %0d actual %0d",
                         $time, want.queries_hit, got.queries_hit);
                mismatches++;
            end
        endfunction
    endclass

    bloom_scoreboard sb;
    bit              quiet;
    t_probes         added_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // the timeout also has to cover the store sweep
    initial begin
        #10_000_000;
        $display("timeout at %0t", $time);
        $display("[three_probe_bloom_filter] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // keep the position bits, scramble the ignored upper bits
    function automatic logic [WORD_W-1:0] noisy_upper(logic [WORD_W-1:0] w);
        return (w & POS_MASK) | ($urandom() & ~POS_MASK);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        // a quarter of the words land in a small dense region to force overlaps
        if ($urandom_range(0, 3) == 0)
            return noisy_upper(WORD_W'($urandom_range(0, 1023)));
        return $urandom();
    endfunction

    task automatic send_item(input logic action, input t_probes probes);
        while (!quiet && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= action;
        s_axis_tdata <= probes;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(action, probes);
        if (action == ACT_ADD) begin
            added_pool.push_back(probes);
            if (added_pool.size() > POOL_MAX)
                void'(added_pool.pop_front());
        end
    endtask

    task automatic run_directed();
        t_probes k;
        t_probes d;
        send_item(ACT_QUERY, '0);                           // empty store
        send_item(ACT_ADD, '0);                             // same bit three times
        send_item(ACT_QUERY, '0);
        send_item(ACT_ADD, {3{32'hFFFF_FFFF}});
        send_item(ACT_QUERY, {3{32'hFFFF_FFFF}});
        send_item(ACT_QUERY, {3{32'h000F_FFFF}});           // upper bits ignored
        send_item(ACT_ADD, {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
        send_item(ACT_QUERY, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
        k = {32'h1234_5678, 32'h0BAD_F00D, 32'hCAFE_0042};
        d = {32'h0001_1111, 32'h0002_2222, 32'h0003_3333};
        send_item(ACT_ADD, k);
        send_item(ACT_QUERY, {d[2], k[1], k[0]});           // clear on third probe
        send_item(ACT_QUERY, {k[1], d[1], k[0]});           // clear on second probe
        send_item(ACT_QUERY, {k[1], k[0], d[0]});           // clear on first probe
        send_item(ACT_QUERY, {d[2], d[1], d[0]});
        send_item(ACT_QUERY, {k[0], k[2], k[1]});           // permuted key
        send_item(ACT_QUERY, {k[2] ^ 32'hFFF0_0000, k[1] ^ 32'h8000_0000,
                              k[0] ^ 32'h7FF0_0000});
        send_item(ACT_ADD, {d[2], d[2], d[2]});
        send_item(ACT_QUERY, {d[2], d[2], d[2]});
        send_item(ACT_QUERY, {d[2], k[1], k[0]});           // now all set
        send_item(ACT_ADD, {32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF});
        send_item(ACT_QUERY, {32'h0000_0000, 32'h0000_0001, 32'h000F_FFFF});
    endtask

    task automatic run_random();
        t_probes k;
        t_probes m;
        int      pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500 && n < 700);
            pick = $urandom_range(0, 99);
            k = added_pool[$urandom_range(0, added_pool.size() - 1)];
            if (pick < 35) begin
                for (int i = 0; i < PROBES; i++)
                    k[i] = random_word();
                send_item(ACT_ADD, k);
            end else if (pick < 65) begin
                for (int i = 0; i < PROBES; i++)
                    k[i] = noisy_upper(k[i]);
                send_item(ACT_QUERY, k);
            end else if (pick < 80) begin
                k[$urandom_range(0, PROBES - 1)] = random_word();
                send_item(ACT_QUERY, k);
            end else if (pick < 90) begin
                // each probe borrowed from a randomly picked added key
                for (int i = 0; i < PROBES; i++) begin
                    m = added_pool[$urandom_range(0, added_pool.size() - 1)];
                    k[i] = noisy_upper(m[$urandom_range(0, PROBES - 1)]);
                end
                send_item(ACT_QUERY, k);
            end else begin
                for (int i = 0; i < PROBES; i++)
                    k[i] = random_word();
                send_item(ACT_QUERY, k);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= ACT_ADD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d adds, %0d query hits and %0d query misses",
                 sb.add_count, sb.hit_count, sb.miss_count);
        $display("%0d results compared, %0d mismatches", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[three_probe_bloom_filter] OK");
        end else begin
            $display("[three_probe_bloom_filter] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tpbf_pkg.sv
rtl/tpbf_result_fifo.sv
rtl/three_probe_bloom_filter.sv
test/three_probe_bloom_filter_tb.sv
